// ===== design/cartpole_dynamics_step_top_assert.svh =====
// Assertion macros shared by the cart-pole RTL.
// Each macro wraps one concurrent assertion clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
`ifndef CARTPOLE_DYNAMICS_STEP_TOP_ASSERT_SVH
`define CARTPOLE_DYNAMICS_STEP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cartpole assertion failed");
`define CPD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("cartpole forbidden condition seen");
`else
`define CPD_ASSERT(lbl, clk, rst_n, prop)
`define CPD_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== design/cpd_pkg.sv =====
`default_nettype none
package cpd_pkg;

  // Q8.24 constants.
  localparam logic signed [31:0] Q_GRAVITY         = 32'sd164416717;
  localparam logic signed [31:0] Q_INV_TOTAL_MASS  = 32'sd15252015;
  localparam logic signed [31:0] Q_MASSPOLE        = 32'sd1677722;
  localparam logic signed [31:0] Q_HALF_LENGTH     = 32'sd8388608;
  localparam logic signed [31:0] Q_POLEMASS_LENGTH = 32'sd838861;
  localparam logic signed [31:0] Q_FORCE           = 32'sd167772160;
  localparam logic signed [31:0] Q_TAU             = 32'sd335544;
  localparam logic signed [32:0] Q_THETA_LIMIT     = 33'sd3506438;
  localparam logic signed [32:0] Q_X_LIMIT         = 33'sd40265318;
  localparam logic signed [33:0] Q_FOUR_THIRDS     = 34'sd22369621;
  localparam logic signed [33:0] Q_PI              = 34'sd52707179;
  localparam logic signed [33:0] Q_HALF_PI         = 34'sd26353589;
  localparam logic signed [33:0] Q_TWO_PI          = 34'sd105414357;
  localparam logic signed [33:0] Q_CORDIC_GAIN     = 34'sd10188014;
  localparam int                 CORDIC_ITERS      = 24;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD,
    ST_CAP,
    ST_RED,
    ST_FOLD,
    ST_CORDIC,
    ST_MUL,
    ST_DIV,
    ST_DIVEND,
    ST_WB,
    ST_OUT
  } state_t;

  // Multiply sequence of one Euler step, in execution order.
  typedef enum logic [4:0] {
    OP_WW,
    OP_PML_WW,
    OP_TIMES_S,
    OP_INV_TEMP,
    OP_GRAV_S,
    OP_C_TEMP,
    OP_CC,
    OP_MP,
    OP_INV_DEN,
    OP_HALF,
    OP_PML_TH,
    OP_TIMES_C,
    OP_INV_XACC,
    OP_TAU_XD,
    OP_TAU_XACC,
    OP_TAU_W,
    OP_TAU_TH
  } op_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh07FFFFFFF) begin
      r = Q_MAX;
    end else if (v < -34'sh080000000) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Round half up, drop 24 fraction bits, saturate.
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [63:0] sh;
    logic signed [31:0] r;
    t  = p + 64'sd8388608;
    sh = t >>> 24;
    if (sh > 64'sh000000007FFFFFFF) begin
      r = Q_MAX;
    end else if (sh < -64'sh0000000080000000) begin
      r = Q_MIN;
    end else begin
      r = sh[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [32:0] abs33(input logic signed [31:0] v);
    logic signed [32:0] e;
    e = {v[31], v};
    return (e < 0) ? -e : e;
  endfunction

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [33:0] atan_q(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd13176795;
      5'd1:  r = 34'sd7778716;
      5'd2:  r = 34'sd4110060;
      5'd3:  r = 34'sd2086331;
      5'd4:  r = 34'sd1047214;
      5'd5:  r = 34'sd524117;
      5'd6:  r = 34'sd262123;
      5'd7:  r = 34'sd131069;
      5'd8:  r = 34'sd65536;
      5'd9:  r = 34'sd32768;
      5'd10: r = 34'sd16384;
      5'd11: r = 34'sd8192;
      5'd12: r = 34'sd4096;
      5'd13: r = 34'sd2048;
      5'd14: r = 34'sd1024;
      5'd15: r = 34'sd512;
      5'd16: r = 34'sd256;
      5'd17: r = 34'sd128;
      5'd18: r = 34'sd64;
      5'd19: r = 34'sd32;
      5'd20: r = 34'sd16;
      5'd21: r = 34'sd8;
      5'd22: r = 34'sd4;
      5'd23: r = 34'sd2;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/cpd_ram.sv =====
`default_nettype none
module cpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== design/cartpole_dynamics_step_top.sv =====
// Cart-pole dynamics engine for a bank of independent environments.
// Items arrive on the in_ stream: tuser selects step (0) or load (1),
// tdata carries the environment index, the push direction and the four
// Q8.24 state values used by a load. Every item yields exactly one result
// item on the out_ stream: the new state, the step count, tuser = reward
// and tlast = done. The cfg_ channel writes the episode step limit; it is
// always ready; the user must write it only while the block is idle, as
// the block itself does not enforce this. The block works on one item at
// a time. A load goes from acceptance through the load state to the output
// register. A step runs the state memory read, angle reduction, one fold,
// 24 CORDIC iterations, 17 products on the shared 32x32 multiplier (each
// registered before rounding), with the bit-serial divider that forms the
// angular acceleration inside that sequence, and then writes back and
// presents the result. A new item is accepted as soon as the engine is
// idle, even while the last result still waits in the output register; if
// the receiver stalls, the next result holds in the engine until the
// register frees.
// Reset returns the engine to idle, empties the output register and sets
// the step limit to 500; the state memories are not cleared, so an
// environment must be loaded before it is stepped.
`default_nettype none
module cartpole_dynamics_step_top
  import cpd_pkg::*;
#(
  parameter int ENV_COUNT = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // cfg_data: episode step limit
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // in_tdata: env_index[5:0], push_right[6], init_position[38:7],
  // init_velocity[70:39], init_angle[102:71], init_angular_rate[134:103],
  // zero pad[135]
  input  wire logic [135:0] in_tdata,
  // in_tuser: req_type
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_tdata: out_env_index[5:0], position[37:6], velocity[69:38],
  // angle[101:70], angular_rate[133:102], steps_taken[149:134], zero pad
  // [151:150]
  output logic [151:0]      out_tdata,
  // out_tuser: reward
  output logic              out_tuser,
  // out_tlast: done_res
  output logic              out_tlast
);

  localparam int ADDR_W = (ENV_COUNT > 1) ? $clog2(ENV_COUNT) : 1;

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic               ph_r, ph_nxt;
  logic [4:0]         iter_r, iter_nxt;
  logic [5:0]         div_cnt_r, div_cnt_nxt;
  logic [5:0]         env_r, env_nxt;
  logic               push_r, push_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [151:0]       out_data_r, out_data_nxt;
  logic               out_user_r, out_user_nxt;
  logic               out_last_r, out_last_nxt;
  logic [15:0]        max_steps_r, max_steps_nxt;
  logic signed [31:0] x_r, x_nxt, xd_r, xd_nxt, th_r, th_nxt, w_r, w_nxt;
  logic [15:0]        cnt_r, cnt_nxt;
  logic               reward_r, reward_nxt;
  logic               done_r, done_nxt;
  logic signed [33:0] red_r, red_nxt;
  logic               flip_r, flip_nxt;
  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [31:0] s_r, s_nxt, c_r, c_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [31:0] acc_r, acc_nxt, temp_r, temp_nxt, num_r, num_nxt;
  logic signed [31:0] den_r, den_nxt, thacc_r, thacc_nxt;
  logic [55:0]        q_r, q_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic               neg_r, neg_nxt;

  logic               in_fire;
  logic               bad_index;
  logic signed [31:0] mul_a, mul_b, qv, force_q;
  logic signed [33:0] dx, dy, at;
  logic [32:0]        trial;
  logic               trial_ge;
  logic [15:0]        cnt_inc;
  logic signed [32:0] num_abs;
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;
  logic [127:0]       cart_rd;
  logic [15:0]        count_rd;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign bad_index  = (32'(in_tdata[5:0]) >= ENV_COUNT);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // One item is in flight at a time and its write-back finishes before the
  // next item can be accepted, so reads never overlap a pending write.
  assign mem_addr = ADDR_W'(env_r);
  assign mem_we   = (state_r == ST_LOAD) || (state_r == ST_WB);

  cpd_ram #(
    .WIDTH (128),
    .DEPTH (ENV_COUNT)
  ) u_cart_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_addr),
    .wr_data ({w_r, th_r, xd_r, x_r}),
    .rd_addr (mem_addr),
    .rd_data (cart_rd)
  );

  cpd_ram #(
    .WIDTH (16),
    .DEPTH (ENV_COUNT)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_addr),
    .wr_data (cnt_nxt),
    .rd_addr (mem_addr),
    .rd_data (count_rd)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = acc_r;
    mul_b = acc_r;
    case (op_r)
      OP_WW:       begin mul_a = w_r;               mul_b = w_r;              end
      OP_PML_WW:   begin mul_a = Q_POLEMASS_LENGTH; mul_b = acc_r;            end
      OP_TIMES_S:  begin mul_a = acc_r;             mul_b = s_r;              end
      OP_INV_TEMP: begin mul_a = acc_r;             mul_b = Q_INV_TOTAL_MASS; end
      OP_GRAV_S:   begin mul_a = Q_GRAVITY;         mul_b = s_r;              end
      OP_C_TEMP:   begin mul_a = c_r;               mul_b = temp_r;           end
      OP_CC:       begin mul_a = c_r;               mul_b = c_r;              end
      OP_MP:       begin mul_a = Q_MASSPOLE;        mul_b = acc_r;            end
      OP_INV_DEN:  begin mul_a = acc_r;             mul_b = Q_INV_TOTAL_MASS; end
      OP_HALF:     begin mul_a = Q_HALF_LENGTH;     mul_b = acc_r;            end
      OP_PML_TH:   begin mul_a = Q_POLEMASS_LENGTH; mul_b = thacc_r;          end
      OP_TIMES_C:  begin mul_a = acc_r;             mul_b = c_r;              end
      OP_INV_XACC: begin mul_a = acc_r;             mul_b = Q_INV_TOTAL_MASS; end
      OP_TAU_XD:   begin mul_a = Q_TAU;             mul_b = xd_r;             end
      OP_TAU_XACC: begin mul_a = Q_TAU;             mul_b = acc_r;            end
      OP_TAU_W:    begin mul_a = Q_TAU;             mul_b = w_r;              end
      OP_TAU_TH:   begin mul_a = Q_TAU;             mul_b = thacc_r;          end
      default:     begin mul_a = acc_r;             mul_b = acc_r;            end
    endcase
  end

  assign qv      = qround(prod_r);
  assign force_q = push_r ? Q_FORCE : -Q_FORCE;
  assign dx      = cy_r >>> iter_r;
  assign dy      = cx_r >>> iter_r;
  assign at      = atan_q(iter_r);
  assign trial   = {rem_r, q_r[55]};
  assign trial_ge = (trial >= {1'b0, den_r});
  assign cnt_inc = (cnt_r == 16'hFFFF) ? cnt_r : cnt_r + 16'd1;
  assign num_abs = abs33(num_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ph_nxt        = ph_r;
    iter_nxt      = iter_r;
    div_cnt_nxt   = div_cnt_r;
    env_nxt       = env_r;
    push_nxt      = push_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    max_steps_nxt = max_steps_r;
    x_nxt         = x_r;
    xd_nxt        = xd_r;
    th_nxt        = th_r;
    w_nxt         = w_r;
    cnt_nxt       = cnt_r;
    reward_nxt    = reward_r;
    done_nxt      = done_r;
    red_nxt       = red_r;
    flip_nxt      = flip_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    s_nxt         = s_r;
    c_nxt         = c_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    temp_nxt      = temp_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    thacc_nxt     = thacc_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;

    if (cfg_valid && cfg_ready) begin
      max_steps_nxt = cfg_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          env_nxt    = in_tdata[5:0];
          push_nxt   = in_tdata[6];
          cnt_nxt    = 16'd0;
          reward_nxt = 1'b0;
          done_nxt   = bad_index;
          if (bad_index) begin
            x_nxt     = 32'sd0;
            xd_nxt    = 32'sd0;
            th_nxt    = 32'sd0;
            w_nxt     = 32'sd0;
            state_nxt = ST_OUT;
          end else begin
            x_nxt     = in_tdata[38:7];
            xd_nxt    = in_tdata[70:39];
            th_nxt    = in_tdata[102:71];
            w_nxt     = in_tdata[134:103];
            state_nxt = in_tuser ? ST_LOAD : ST_RD;
          end
        end
      end
      ST_LOAD: begin
        state_nxt = ST_OUT;
      end
      ST_RD: begin
        state_nxt = ST_CAP;
      end
      ST_CAP: begin
        x_nxt     = cart_rd[31:0];
        xd_nxt    = cart_rd[63:32];
        th_nxt    = cart_rd[95:64];
        w_nxt     = cart_rd[127:96];
        cnt_nxt   = count_rd;
        red_nxt   = 34'(signed'(cart_rd[95:64]));
        state_nxt = ST_RED;
      end
      ST_RED: begin
        // Bring the angle into [-pi, pi], one period per cycle.
        if (red_r > Q_PI) begin
          red_nxt = red_r - Q_TWO_PI;
        end else if (red_r < -Q_PI) begin
          red_nxt = red_r + Q_TWO_PI;
        end else begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        flip_nxt = 1'b0;
        if (red_r > Q_HALF_PI) begin
          red_nxt  = Q_PI - red_r;
          flip_nxt = 1'b1;
        end else if (red_r < -Q_HALF_PI) begin
          red_nxt  = -Q_PI - red_r;
          flip_nxt = 1'b1;
        end
        cx_nxt    = Q_CORDIC_GAIN;
        cy_nxt    = 34'sd0;
        iter_nxt  = 5'd0;
        state_nxt = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (red_r >= 0) begin
          cx_nxt  = cx_r - dx;
          cy_nxt  = cy_r + dy;
          red_nxt = red_r - at;
        end else begin
          cx_nxt  = cx_r + dx;
          cy_nxt  = cy_r - dy;
          red_nxt = red_r + at;
        end
        iter_nxt = iter_r + 5'd1;
        if (32'(iter_r) == CORDIC_ITERS - 1) begin
          s_nxt     = cy_nxt[31:0];
          c_nxt     = flip_r ? -cx_nxt[31:0] : cx_nxt[31:0];
          op_nxt    = OP_WW;
          ph_nxt    = 1'b0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!ph_r) begin
          prod_nxt = mul_a * mul_b;
          ph_nxt   = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          op_nxt = op_t'(op_r + 5'd1);
          case (op_r)
            OP_WW:       acc_nxt = qv;
            OP_PML_WW:   acc_nxt = qv;
            OP_TIMES_S:  acc_nxt = sat32(34'(force_q) + 34'(qv));
            OP_INV_TEMP: temp_nxt = qv;
            OP_GRAV_S:   num_nxt = qv;
            OP_C_TEMP:   num_nxt = sat32(34'(num_r) - 34'(qv));
            OP_CC:       acc_nxt = qv;
            OP_MP:       acc_nxt = qv;
            OP_INV_DEN:  acc_nxt = sat32(Q_FOUR_THIRDS - 34'(qv));
            OP_HALF: begin
              den_nxt     = (qv < 32'sd1) ? 32'sd1 : qv;
              neg_nxt     = num_r[31];
              q_nxt       = {num_abs[31:0], 24'd0};
              rem_nxt     = 32'd0;
              div_cnt_nxt = 6'd0;
              state_nxt   = ST_DIV;
            end
            OP_PML_TH:   acc_nxt = qv;
            OP_TIMES_C:  acc_nxt = qv;
            OP_INV_XACC: acc_nxt = sat32(34'(temp_r) - 34'(qv));
            OP_TAU_XD:   x_nxt = sat32(34'(x_r) + 34'(qv));
            OP_TAU_XACC: xd_nxt = sat32(34'(xd_r) + 34'(qv));
            OP_TAU_W:    th_nxt = sat32(34'(th_r) + 34'(qv));
            OP_TAU_TH: begin
              w_nxt     = sat32(34'(w_r) + 34'(qv));
              state_nxt = ST_WB;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        rem_nxt     = trial_ge ? 32'(trial - {1'b0, den_r}) : trial[31:0];
        q_nxt       = {q_r[54:0], trial_ge};
        div_cnt_nxt = div_cnt_r + 6'd1;
        if (div_cnt_r == 6'd55) begin
          state_nxt = ST_DIVEND;
        end
      end
      ST_DIVEND: begin
        if (neg_r) begin
          thacc_nxt = (q_r > 56'h80000000) ? Q_MIN : -q_r[31:0];
        end else begin
          thacc_nxt = (q_r > 56'h7FFFFFFF) ? Q_MAX : q_r[31:0];
        end
        op_nxt    = OP_PML_TH;
        ph_nxt    = 1'b0;
        state_nxt = ST_MUL;
      end
      ST_WB: begin
        cnt_nxt    = cnt_inc;
        reward_nxt = 1'b1;
        done_nxt   = (abs33(x_r) > Q_X_LIMIT) || (abs33(th_r) > Q_THETA_LIMIT) ||
                     (cnt_inc >= max_steps_r);
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, cnt_r, w_r, th_r, xd_r, x_r, env_r};
          out_user_nxt  = reward_r;
          out_last_nxt  = done_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      max_steps_r <= 16'd500;
      op_r        <= OP_WW;
      ph_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      max_steps_r <= max_steps_nxt;
      op_r        <= op_nxt;
      ph_r        <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iter_r     <= iter_nxt;
    div_cnt_r  <= div_cnt_nxt;
    env_r      <= env_nxt;
    push_r     <= push_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
    x_r        <= x_nxt;
    xd_r       <= xd_nxt;
    th_r       <= th_nxt;
    w_r        <= w_nxt;
    cnt_r      <= cnt_nxt;
    reward_r   <= reward_nxt;
    done_r     <= done_nxt;
    red_r      <= red_nxt;
    flip_r     <= flip_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    s_r        <= s_nxt;
    c_r        <= c_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    temp_r     <= temp_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    thacc_r    <= thacc_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
  end

`include "cartpole_dynamics_step_top_assert.svh"

  // Range reduction has finished before the fold.
  `CPD_ASSERT(a_reduced, clk, rst_n, (state_r == ST_FOLD) |-> (red_r <= Q_PI && red_r >= -Q_PI))
  // CORDIC starts inside its convergence range.
  `CPD_ASSERT(a_folded, clk, rst_n, (state_r == ST_CORDIC && iter_r == 5'd0) |-> (red_r <= Q_HALF_PI && red_r >= -Q_HALF_PI))
  // The divider never sees a zero or negative divisor.
  `CPD_ASSERT(a_den_pos, clk, rst_n, (state_r == ST_DIV) |-> (den_r > 32'sd0))
  // A result enters the output register only from the result state.
  `CPD_ASSERT(a_out_src, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
  // The state memory is never written while the engine is idle.
  `CPD_ASSERT_NEVER(a_no_idle_wr, clk, rst_n, mem_we && state_r == ST_IDLE)

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
module testbench
  import cpd_pkg::*;
();

  // One request item on the in_ stream.
  typedef struct {
    logic               load;
    logic [5:0]         env;
    logic               push_right;
    logic signed [31:0] val [4];
  } request_t;

  // One result item as it should leave the out_ stream.
  typedef struct {
    logic [5:0]         env;
    logic signed [31:0] val [4];
    logic               reward;
    logic               done;
    logic [15:0]        steps;
  } outcome_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 200;
  localparam longint Q_ATAN_ONE = 13176795;

  // The scoreboard keeps its own copy of every environment and of the step
  // limit and predicts the outcome of each accepted request item.
  class cartpole_scoreboard;
    longint       cart_vals [64][4];
    int unsigned  step_counts [64];
    int unsigned  step_limit;
    longint       atan_steps [CORDIC_ITERS];
    outcome_t     pending_outcomes [$];
    int           mismatches;

    function new();
      int unsigned i, k;
      longint unsigned acc, term;
      step_limit = 500;
      mismatches = 0;
      foreach (step_counts[e]) step_counts[e] = 0;
      atan_steps[0] = Q_ATAN_ONE;
      // Arctangent of 2^-i by its power series, held at 62 fraction bits.
      for (i = 1; i < CORDIC_ITERS; i++) begin
        acc = 0;
        for (k = 0; i * (2 * k + 1) <= 62; k++) begin
          term = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
          if (k % 2 == 1) acc -= term; else acc += term;
        end
        atan_steps[i] = longint'((acc + (64'd1 << 37)) >> 38);
      end
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Q8.24 product: round half up, then saturate.
    function longint fixmul(longint a, longint b);
      return clamp32((a * b + 64'sd8388608) >>> 24);
    endfunction

    function void sine_cosine(longint ang, output longint s, output longint c);
      longint r, x, y, t, dx, dy;
      bit flip;
      int i;
      r = ang % longint'(Q_TWO_PI);
      x = Q_CORDIC_GAIN;
      y = 0;
      flip = 0;
      if (r > Q_PI) r -= Q_TWO_PI;
      if (r < -Q_PI) r += Q_TWO_PI;
      // Fold into the right half plane; cosine changes sign there.
      if (r > Q_HALF_PI) begin
        r = Q_PI - r;
        flip = 1;
      end else if (r < -Q_HALF_PI) begin
        r = -Q_PI - r;
        flip = 1;
      end
      for (i = 0; i < CORDIC_ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (r >= 0) begin
          t = x - dx;
          y = y + dy;
          r -= atan_steps[i];
        end else begin
          t = x + dx;
          y = y - dy;
          r += atan_steps[i];
        end
        x = t;
      end
      s = y;
      c = flip ? -x : x;
    endfunction

    // One explicit Euler step of the cart-pole equations in Q8.24.
    function void euler_step(int e, bit push_right, output longint nv [4]);
      longint x, xd, th, w, s, c, force_q, temp, num, den, thacc, xacc;
      x = cart_vals[e][0];
      xd = cart_vals[e][1];
      th = cart_vals[e][2];
      w = cart_vals[e][3];
      sine_cosine(th, s, c);
      force_q = push_right ? longint'(Q_FORCE) : -longint'(Q_FORCE);
      temp = fixmul(fixmul(Q_POLEMASS_LENGTH, fixmul(w, w)), s);
      temp = fixmul(clamp32(force_q + temp), Q_INV_TOTAL_MASS);
      num = clamp32(fixmul(Q_GRAVITY, s) - fixmul(c, temp));
      den = fixmul(fixmul(Q_MASSPOLE, fixmul(c, c)), Q_INV_TOTAL_MASS);
      den = fixmul(Q_HALF_LENGTH, clamp32(longint'(Q_FOUR_THIRDS) - den));
      if (den < 1) den = 1;
      thacc = clamp32((num * 64'sd16777216) / den);
      xacc = fixmul(fixmul(fixmul(Q_POLEMASS_LENGTH, thacc), c), Q_INV_TOTAL_MASS);
      xacc = clamp32(temp - xacc);
      nv[0] = clamp32(x + fixmul(Q_TAU, xd));
      nv[1] = clamp32(xd + fixmul(Q_TAU, xacc));
      nv[2] = clamp32(th + fixmul(Q_TAU, w));
      nv[3] = clamp32(w + fixmul(Q_TAU, thacc));
    endfunction

    function void note_request(request_t rq);
      outcome_t o;
      longint nv [4];
      longint ax, ath;
      int k;
      o.env = rq.env;
      if (rq.load) begin
        for (k = 0; k < 4; k++) begin
          cart_vals[rq.env][k] = rq.val[k];
          o.val[k] = rq.val[k];
        end
        step_counts[rq.env] = 0;
        o.reward = 0;
        o.done = 0;
        o.steps = 0;
      end else begin
        euler_step(rq.env, rq.push_right, nv);
        for (k = 0; k < 4; k++) begin
          cart_vals[rq.env][k] = nv[k];
          o.val[k] = nv[k][31:0];
        end
        if (step_counts[rq.env] < 65535) step_counts[rq.env]++;
        ax = (nv[0] < 0) ? -nv[0] : nv[0];
        ath = (nv[2] < 0) ? -nv[2] : nv[2];
        o.reward = 1;
        o.done = (ax > Q_X_LIMIT) || (ath > Q_THETA_LIMIT) ||
                 (step_counts[rq.env] >= step_limit);
        o.steps = step_counts[rq.env][15:0];
      end
      pending_outcomes.push_back(o);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      mismatches++;
    endtask

    task check_result(logic [151:0] data, logic reward, logic done);
      outcome_t o;
      int k;
      if (pending_outcomes.size() == 0) begin
        report("unexpected result, env", data[5:0], -1);
        return;
      end
      o = pending_outcomes.pop_front();
      if (data[5:0] !== o.env) report("env_index", data[5:0], o.env);
      for (k = 0; k < 4; k++)
        if ($signed(data[6 + 32 * k +: 32]) !== o.val[k])
          report($sformatf("state value %0d", k),
                 $signed(data[6 + 32 * k +: 32]), o.val[k]);
      if (reward !== o.reward) report("reward", reward, o.reward);
      if (done !== o.done) report("done", done, o.done);
      if (data[149:134] !== o.steps) report("steps_taken", data[149:134], o.steps);
      if (data[151:150] !== 2'b00) report("pad bits", data[151:150], 0);
    endtask
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         in_tuser = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [151:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  cartpole_dynamics_step_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  cartpole_scoreboard book = new();
  bit loaded [64];
  bit idling_on = 1;
  int stall_left = 0;
  int quiet_cycles = 0;

  // Result side: check every accepted result item, stall the receiver in
  // random bursts, and stop the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) book.check_result(out_tdata, out_tuser, out_tlast);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (idling_on && rst_n && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 4);
      out_tready <= 0;
    end else begin
      out_tready <= rst_n;
    end
  end

  // Waits until every outstanding result has come back and lets the engine
  // settle, then writes the step limit.
  task automatic write_limit(logic [15:0] limit);
    in_tvalid <= 0;
    while (book.pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= limit;
    do @(posedge clk); while (!cfg_ready);
    book.step_limit = limit;
    cfg_valid <= 0;
  endtask

  // Offers one request item and waits for it to be accepted. A gap in front
  // of the item lowers valid; otherwise valid stays high from the last item.
  task automatic send_request(request_t rq);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= rq.load;
    in_tdata <= {1'b0, rq.val[3], rq.val[2], rq.val[1], rq.val[0],
                 rq.push_right, rq.env};
    do @(posedge clk); while (!in_tready);
    book.note_request(rq);
    if (rq.load) loaded[rq.env] = 1;
  endtask

  task automatic load_env(int e, int x, int xd, int th, int w);
    request_t rq;
    rq.load = 1;
    rq.env = 6'(e);
    rq.push_right = 1'($urandom_range(0, 1));
    rq.val[0] = x;
    rq.val[1] = xd;
    rq.val[2] = th;
    rq.val[3] = w;
    send_request(rq);
  endtask

  task automatic step_env(int e, bit right);
    request_t rq;
    int k;
    rq.load = 0;
    rq.env = 6'(e);
    rq.push_right = right;
    // A step ignores the state fields, so they carry noise.
    for (k = 0; k < 4; k++) rq.val[k] = $urandom;
    send_request(rq);
  endtask

  // Mostly small, physically sensible values; sometimes any 32-bit value.
  function automatic int random_q();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return int'($urandom_range(0, 1677722)) - 838861;
  endfunction

  task automatic random_items(int count);
    int n, e;
    for (n = 0; n < count; n++) begin
      // Favor a few environments so that episodes run long.
      e = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
      if (!loaded[e] || $urandom_range(0, 9) == 0) begin
        load_env(e, random_q(), random_q(), random_q(), random_q());
      end else begin
        step_env(e, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    logic [15:0] limits [6];
    int p;
    foreach (loaded[e]) loaded[e] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: both pushes from rest, the extreme indexes and values,
    // angles that need folding and range reduction, and the bounds checks.
    load_env(0, 0, 0, 0, 0);
    step_env(0, 1);
    step_env(0, 0);
    load_env(63, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    step_env(63, 1);
    load_env(1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    step_env(1, 0);
    load_env(2, 0, 0, 50331648, 0);              // about 3 rad, folded
    step_env(2, 1);
    load_env(3, 0, 0, -50331648, 16777216);      // about -3 rad, folded
    step_env(3, 0);
    load_env(4, 40265318, 1000000, 3506438, 0);  // right at both bounds
    step_env(4, 1);
    load_env(5, -40265318, -1000000, -3506438, 0);
    step_env(5, 0);
    // Step limit of one: the first step is done, and stepping continues.
    write_limit(1);
    step_env(0, 1);
    step_env(0, 0);
    // A zero limit marks every step done.
    write_limit(0);
    step_env(2, 0);
    load_env(2, 0, 0, 0, 0);
    step_env(2, 1);

    limits[0] = 16'hFFFF;
    limits[1] = 3;
    limits[2] = 16'($urandom_range(2, 300));
    limits[3] = 0;
    limits[4] = 1;
    limits[5] = 500;
    for (p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      if (p == 5) idling_on = 0;
      random_items(64);
    end
    in_tvalid <= 0;

    while (book.pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.pending_outcomes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
